/* rtl/sld_pkg.sv */
// Shared widths, constants and unit request types for the soil layer drainage block.
package sld_pkg;

	localparam int LEN_W     = 20;
	localparam int MST_W     = 16;
	localparam int ITN_W     = 16;
	localparam int TOT_W     = 22;
	localparam int QUO_W     = 16;
	localparam int REL_W     = QUO_W + 1;
	localparam int DIV_STEPS = QUO_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int MUL_A_W   = 36;
	localparam int MUL_B_W   = 17;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

	localparam logic [REL_W-1:0] ONE_Q16 = REL_W'(1) << QUO_W;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [TOT_W-1:0] TOT_MAX = '1;
	localparam logic [LEN_W-1:0] THR_RST = LEN_W'(1);

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [MST_W-1:0] mst_t;
	typedef logic [ITN_W-1:0] itn_t;
	typedef logic [TOT_W-1:0] tot_t;
	typedef logic [QUO_W-1:0] quo_t;
	typedef logic [REL_W-1:0] rel_t;

	typedef struct packed {
		logic start;
		len_t dividend;
		len_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		quo_t quo;
	} div_rsp_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

/* rtl/sld_if.sv */
// Request and result channel interfaces of the soil layer drainage block.
interface sld_in_if import sld_pkg::*; ();
	logic valid;
	logic ready;
	logic first_layer;
	logic last_layer;
	len_t drain_depth;
	len_t layer_depth;
	mst_t moisture;
	mst_t field_capacity;
	mst_t saturation;
	itn_t intensity;

	modport source (
		output valid, first_layer, last_layer, drain_depth, layer_depth,
		output moisture, field_capacity, saturation, intensity,
		input  ready
	);
	modport sink (
		input  valid, first_layer, last_layer, drain_depth, layer_depth,
		input  moisture, field_capacity, saturation, intensity,
		output ready
	);
endinterface

interface sld_out_if import sld_pkg::*; ();
	logic valid;
	logic ready;
	len_t layer_drainage;
	mst_t new_moisture;
	logic drained;
	logic cell_skipped;
	tot_t cell_total;
	logic last;

	modport source (
		output valid, layer_drainage, new_moisture, drained, cell_skipped,
		output cell_total, last,
		input  ready
	);
	modport sink (
		input  valid, layer_drainage, new_moisture, drained, cell_skipped,
		input  cell_total, last,
		output ready
	);
endinterface

/* rtl/sld_div.sv */
// Shared radix-4 restoring divider: 16-bit quotient of (dividend << 16) / divisor.
module sld_div import sld_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	len_t              rem_q;
	len_t              dvs_q;
	quo_t              quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	logic [LEN_W:0] r1, d1, r2, d2;
	logic           b1, b2;
	len_t           m1, m2;

	always_comb begin
		r1 = {rem_q, 1'b0};
		d1 = r1 - {1'b0, dvs_q};
		b1 = r1 >= {1'b0, dvs_q};
		m1 = b1 ? d1[LEN_W-1:0] : r1[LEN_W-1:0];
		r2 = {m1, 1'b0};
		d2 = r2 - {1'b0, dvs_q};
		b2 = r2 >= {1'b0, dvs_q};
		m2 = b2 ? d2[LEN_W-1:0] : r2[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= m2;
			quo_q <= {quo_q[QUO_W-3:0], b1, b2};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

/* rtl/sld_mul.sv */
// Shared registered multiplier for the drainage product chain.
module sld_mul import sld_pkg::*; (
	input  logic               clk,
	input  mul_req_t           req,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q <= {{(MUL_P_W - MUL_A_W){1'b0}}, req.a} * {{(MUL_P_W - MUL_B_W){1'b0}}, req.b};
		end
	end

	assign p = p_q;

endmodule

/* rtl/soil_layer_drainage_core.sv */
// Soil layer drainage top level: sequencer, layer state, output register and checks.
//
// Usage: in_ch carries one soil layer per request, top layer of a cell first
// (first_layer set), with the cell's drain depth and drainage intensity.
// out_ch returns one result per request: layer drainage, new moisture, the
// drained and skipped flags, the running cell total and the last marker.
// cfg_we/cfg_wdata write skip_threshold, which the user must do only while the
// block is idle; the block itself does not enforce this.
// One request is processed at a time; in_ch.ready is high only when idle, and
// the sequencer returns to idle at the edge that registers the result, so a new
// request is not taken before the last result is registered.
// The cost is set by up to three passes of the shared 2-bit-per-cycle
// divider (8 steps each) plus three passes of the shared multiplier.
// Reset clears the depth above, running total and skip flag, and sets
// skip_threshold to 1. A result held in the output register while out_ch
// is stalled keeps the sequencer waiting before the next request.
module soil_layer_drainage_core import sld_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  len_t         cfg_wdata,
	sld_in_if.sink       in_ch,
	sld_out_if.source    out_ch
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_RDW  = 4'd2;
	localparam logic [3:0] S_WT   = 4'd3;
	localparam logic [3:0] S_WTW  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_M2   = 4'd6;
	localparam logic [3:0] S_M3   = 4'd7;
	localparam logic [3:0] S_M4   = 4'd8;
	localparam logic [3:0] S_NDW  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	function automatic tot_t sat_add(input tot_t a, input tot_t b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
	endfunction

	logic [3:0] state_q;
	len_t       thr_q;
	tot_t       da_q;
	tot_t       rt_q;
	logic       skip_q;
	logic       out_valid_q;

	logic last_q;
	len_t dd_q;
	len_t ld_q;
	mst_t m_q;
	mst_t fc_q;
	mst_t sat_q;
	itn_t inten_q;
	rel_t rd_q;
	rel_t wt_q;
	len_t drain_q;
	mst_t newm_q;
	logic drained_q;

	len_t layer_drainage_q;
	mst_t new_moisture_q;
	logic drained_out_q;
	logic cell_skipped_q;
	tot_t cell_total_q;
	logic last_out_q;

	logic               in_acc;
	logic               out_free;
	logic [23:0]        num;
	logic               num_neg, num_zero, num_ge;
	mst_t               ex, span;
	logic               wt_pos;
	rel_t               diff;
	len_t               drain_sat;
	tot_t               da_next, rt_next;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	mul_req_t           mul_req;
	logic [MUL_P_W-1:0] mul_p;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	always_comb begin
		num       = {2'b0, da_q} + {4'b0, ld_q} - {4'b0, dd_q};
		num_neg   = num[23];
		num_zero  = (num == '0);
		num_ge    = !num_neg && (num[22:0] >= {3'b0, ld_q});
		ex        = m_q - fc_q;
		span      = sat_q - fc_q;
		wt_pos    = (m_q > fc_q) && (sat_q > fc_q);
		diff      = wt_q - rd_q;
		drain_sat = (|mul_p[MUL_P_W-1:48]) ? LEN_MAX : mul_p[47:28];
		da_next   = sat_add(da_q, {{(TOT_W - LEN_W){1'b0}}, ld_q});
		rt_next   = sat_add(rt_q, {{(TOT_W - LEN_W){1'b0}}, drain_q});
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = num[LEN_W-1:0];
		div_req.divisor  = ld_q;
		case (state_q)
			S_CHK: begin
				div_req.start = !skip_q && (ld_q != '0) && !num_neg && !num_zero && !num_ge;
			end
			S_WT: begin
				div_req.start    = wt_pos && (m_q < sat_q);
				div_req.dividend = {{(LEN_W - MST_W){1'b0}}, ex};
				div_req.divisor  = {{(LEN_W - MST_W){1'b0}}, span};
			end
			S_M4: begin
				div_req.start    = drain_sat < ld_q;
				div_req.dividend = drain_sat;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = {{(MUL_A_W - MST_W){1'b0}}, ex};
		mul_req.b     = diff;
		case (state_q)
			S_CMP: begin
				mul_req.start = wt_q > rd_q;
			end
			S_M2: begin
				mul_req.start = 1'b1;
				mul_req.a     = {{(MUL_A_W - LEN_W){1'b0}}, ld_q};
				mul_req.b     = {1'b0, mul_p[31:16]};
			end
			S_M3: begin
				mul_req.start = 1'b1;
				mul_req.a     = mul_p[MUL_A_W-1:0];
				mul_req.b     = {1'b0, inten_q};
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	sld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sld_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= THR_RST;
			da_q        <= '0;
			rt_q        <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.first_layer) begin
							da_q   <= '0;
							rt_q   <= '0;
							skip_q <= in_ch.drain_depth < thr_q;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (skip_q || ld_q == '0) begin
						state_q <= S_OUT;
					end else if (div_req.start) begin
						state_q <= S_RDW;
					end else begin
						state_q <= S_WT;
					end
				end
				S_RDW: begin
					if (div_rsp.done) begin
						state_q <= S_WT;
					end
				end
				S_WT: begin
					state_q <= div_req.start ? S_WTW : S_CMP;
				end
				S_WTW: begin
					if (div_rsp.done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= mul_req.start ? S_M2 : S_OUT;
				end
				S_M2: begin
					state_q <= S_M3;
				end
				S_M3: begin
					state_q <= S_M4;
				end
				S_M4: begin
					state_q <= div_req.start ? S_NDW : S_OUT;
				end
				S_NDW: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (!skip_q) begin
							da_q <= da_next;
							rt_q <= rt_next;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					last_q    <= in_ch.last_layer;
					dd_q      <= in_ch.drain_depth;
					ld_q      <= in_ch.layer_depth;
					m_q       <= in_ch.moisture;
					fc_q      <= in_ch.field_capacity;
					sat_q     <= in_ch.saturation;
					inten_q   <= in_ch.intensity;
					drain_q   <= '0;
					newm_q    <= in_ch.moisture;
					drained_q <= 1'b0;
				end
			end
			S_CHK: begin
				rd_q <= num_ge ? ONE_Q16 : '0;
			end
			S_RDW: begin
				if (div_rsp.done) begin
					rd_q <= {1'b0, div_rsp.quo};
				end
			end
			S_WT: begin
				wt_q <= (wt_pos && m_q >= sat_q) ? ONE_Q16 : '0;
			end
			S_WTW: begin
				if (div_rsp.done) begin
					wt_q <= {1'b0, div_rsp.quo};
				end
			end
			S_M4: begin
				drain_q   <= drain_sat;
				drained_q <= 1'b1;
				newm_q    <= '0;
			end
			S_NDW: begin
				if (div_rsp.done) begin
					newm_q <= (div_rsp.quo >= m_q) ? '0 : m_q - div_rsp.quo;
				end
			end
			S_OUT: begin
				if (out_free) begin
					layer_drainage_q <= drain_q;
					new_moisture_q   <= newm_q;
					drained_out_q    <= drained_q;
					cell_skipped_q   <= skip_q;
					cell_total_q     <= skip_q ? rt_q : rt_next;
					last_out_q       <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.layer_drainage = layer_drainage_q;
	assign out_ch.new_moisture   = new_moisture_q;
	assign out_ch.drained        = drained_out_q;
	assign out_ch.cell_skipped   = cell_skipped_q;
	assign out_ch.cell_total     = cell_total_q;
	assign out_ch.last           = last_out_q;

`ifndef SYNTH
	a_drain_not_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.drained && out_ch.cell_skipped))
		else $error("drained result reported for a skipped cell");

	a_zero_when_dry: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.drained |-> out_ch.layer_drainage == '0)
		else $error("nonzero drainage on a layer that did not drain");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_RDW || state_q == S_WTW || state_q == S_NDW))
		else $error("divider finished outside a wait state");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_CHK)
		else $error("accepted request did not enter the check step");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking testbench for soil_layer_drainage_core with a built-in drainage predictor.
module testbench;
	import sld_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 125;

	typedef struct {
		logic first_layer;
		logic last_layer;
		len_t drain_depth;
		len_t layer_depth;
		mst_t moisture;
		mst_t field_capacity;
		mst_t saturation;
		itn_t intensity;
	} layer_req_t;

	typedef struct {
		len_t layer_drainage;
		mst_t new_moisture;
		logic drained;
		logic cell_skipped;
		tot_t cell_total;
		logic last;
	} layer_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	len_t cfg_wdata;

	sld_in_if  in_ch ();
	sld_out_if out_ch ();

	soil_layer_drainage_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	layer_req_t layer_queue[$];
	layer_res_t drainage_due[$];

	logic [63:0] skip_level = 64'(THR_RST);
	logic [63:0] depth_sum = '0;
	logic [63:0] drain_sum = '0;
	logic        cell_skip = 1'b0;

	int   fails = 0;
	int   cycles = 0;
	int   in_idle_pct = 0;
	int   out_stall_pct = 0;
	logic in_taken = 1'b0;

	function automatic logic [63:0] sat_total(logic [63:0] v);
		return (v > 64'(TOT_MAX)) ? 64'(TOT_MAX) : v;
	endfunction

	function automatic layer_res_t predict_drainage(layer_req_t r);
		layer_res_t  res;
		longint      num;
		logic [63:0] rel_depth, water_table, excess, span, t, drain, q, moist;
		drain = '0;
		moist = 64'(r.moisture);
		res.drained = 1'b0;
		if (r.first_layer) begin
			depth_sum = '0;
			drain_sum = '0;
			cell_skip = 64'(r.drain_depth) < skip_level;
		end
		if (!cell_skip) begin
			if (r.layer_depth != '0) begin
				num = longint'(r.layer_depth) + longint'(depth_sum) - longint'(r.drain_depth);
				if (num <= 0)
					rel_depth = '0;
				else if (num >= longint'(r.layer_depth))
					rel_depth = 64'(ONE_Q16);
				else
					rel_depth = (64'(num) << 16) / 64'(r.layer_depth);
				water_table = '0;
				excess = '0;
				if (r.moisture > r.field_capacity && r.saturation > r.field_capacity) begin
					excess = 64'(r.moisture) - 64'(r.field_capacity);
					span = 64'(r.saturation) - 64'(r.field_capacity);
					water_table = (excess << 16) / span;
					if (water_table > 64'(ONE_Q16))
						water_table = 64'(ONE_Q16);
				end
				if (water_table > rel_depth) begin
					t = ((water_table - rel_depth) * excess) >> 16;
					drain = (t * 64'(r.layer_depth) * 64'(r.intensity)) >> 28;
					if (drain > 64'(LEN_MAX))
						drain = 64'(LEN_MAX);
					q = (drain << 16) / 64'(r.layer_depth);
					moist = (q >= moist) ? '0 : moist - q;
					res.drained = 1'b1;
				end
			end
			depth_sum = sat_total(depth_sum + 64'(r.layer_depth));
			drain_sum = sat_total(drain_sum + drain);
		end
		res.layer_drainage = len_t'(drain);
		res.new_moisture = mst_t'(moist);
		res.cell_skipped = cell_skip;
		res.cell_total = tot_t'(drain_sum);
		res.last = r.last_layer;
		return res;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin : driver
		layer_req_t req;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
			if (!in_ch.valid || in_taken) begin
				if (layer_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					req = layer_queue.pop_front();
					in_ch.first_layer <= req.first_layer;
					in_ch.last_layer <= req.last_layer;
					in_ch.drain_depth <= req.drain_depth;
					in_ch.layer_depth <= req.layer_depth;
					in_ch.moisture <= req.moisture;
					in_ch.field_capacity <= req.field_capacity;
					in_ch.saturation <= req.saturation;
					in_ch.intensity <= req.intensity;
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		layer_req_t req;
		layer_res_t exp_r;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (cfg_we)
				skip_level = 64'(cfg_wdata);
			if (in_ch.valid && in_ch.ready) begin
				req.first_layer = in_ch.first_layer;
				req.last_layer = in_ch.last_layer;
				req.drain_depth = in_ch.drain_depth;
				req.layer_depth = in_ch.layer_depth;
				req.moisture = in_ch.moisture;
				req.field_capacity = in_ch.field_capacity;
				req.saturation = in_ch.saturation;
				req.intensity = in_ch.intensity;
				drainage_due.push_back(predict_drainage(req));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (drainage_due.size() == 0) begin
					$display("%0t: result with none expected, actual drainage %0h total %0h",
						$time, out_ch.layer_drainage, out_ch.cell_total);
					fails++;
				end else begin
					exp_r = drainage_due.pop_front();
					check_field("layer_drainage", 64'(exp_r.layer_drainage),
						64'(out_ch.layer_drainage));
					check_field("new_moisture", 64'(exp_r.new_moisture),
						64'(out_ch.new_moisture));
					check_field("drained", 64'(exp_r.drained), 64'(out_ch.drained));
					check_field("cell_skipped", 64'(exp_r.cell_skipped),
						64'(out_ch.cell_skipped));
					check_field("cell_total", 64'(exp_r.cell_total), 64'(out_ch.cell_total));
					check_field("last", 64'(exp_r.last), 64'(out_ch.last));
				end
			end
		end
	end

	task automatic push_layer(logic fl, logic ll, len_t dd, len_t ld, mst_t m, mst_t fc,
		mst_t sat, itn_t inten);
		layer_req_t r;
		r.first_layer = fl;
		r.last_layer = ll;
		r.drain_depth = dd;
		r.layer_depth = ld;
		r.moisture = m;
		r.field_capacity = fc;
		r.saturation = sat;
		r.intensity = inten;
		layer_queue.push_back(r);
	endtask

	task automatic push_noise();
		push_layer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			len_t'($urandom_range(0, LEN_MAX)), len_t'($urandom_range(1, LEN_MAX)),
			mst_t'($urandom_range(0, 16'hFFFF)), mst_t'($urandom_range(0, 16'hFFFF)),
			mst_t'($urandom_range(0, 16'hFFFF)), itn_t'($urandom_range(0, 16'hFFFF)));
	endtask

	task automatic push_cell(ref int count);
		int          nl;
		len_t        lds[5];
		logic [63:0] sum;
		len_t        dd;
		mst_t        fc, sat, m;
		itn_t        inten;
		nl = int'($urandom_range(1, 5));
		sum = '0;
		for (int i = 0; i < nl; i++) begin
			case ($urandom_range(0, 9))
				0: lds[i] = len_t'($urandom_range(1, LEN_MAX));
				1: lds[i] = len_t'($urandom_range(1, 16));
				default: lds[i] = len_t'($urandom_range(20'h01000, 20'h30000));
			endcase
			sum += 64'(lds[i]);
		end
		case ($urandom_range(0, 5))
			0: dd = len_t'($urandom_range(0, LEN_MAX));
			1: dd = (skip_level == 0) ? len_t'(0) : len_t'(skip_level - $urandom_range(0, 1));
			default: dd = len_t'($urandom_range(0,
				(sum > 64'(LEN_MAX)) ? int'(LEN_MAX) : int'(sum)));
		endcase
		inten = itn_t'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < nl; i++) begin
			fc = mst_t'($urandom_range(0, 16'hC000));
			if ($urandom_range(0, 7) == 0)
				sat = mst_t'($urandom_range(0, fc));
			else
				sat = mst_t'($urandom_range(fc, 16'hFFFF));
			if ($urandom_range(0, 3) == 0)
				m = mst_t'($urandom_range(0, 16'hFFFF));
			else
				m = mst_t'($urandom_range(fc, (sat > fc) ? sat : fc));
			push_layer(i == 0, i == nl - 1, dd, lds[i], m, fc, sat, inten);
		end
		count += nl;
	endtask

	task automatic finish_phase();
		while (layer_queue.size() != 0 || in_ch.valid || drainage_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int   count;
		len_t thr;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.first_layer = 1'b0;
		in_ch.last_layer = 1'b0;
		in_ch.drain_depth = '0;
		in_ch.layer_depth = '0;
		in_ch.moisture = '0;
		in_ch.field_capacity = '0;
		in_ch.saturation = '0;
		in_ch.intensity = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		in_idle_pct = 15;
		out_stall_pct = 64;
		push_layer(0, 0, 20'h00000, 20'h10000, 16'hC000, 16'h4000, 16'hE000, 16'h1000);
		push_layer(1, 0, 20'h00000, 20'h10000, 16'hC000, 16'h4000, 16'hE000, 16'h1000);
		push_layer(0, 1, 20'h00000, 20'h10000, 16'hC000, 16'h4000, 16'hE000, 16'h1000);
		push_layer(1, 0, 20'h30000, 20'h10000, 16'hC000, 16'h4000, 16'hE000, 16'h1000);
		push_layer(0, 0, 20'h30000, 20'h18000, 16'hD000, 16'h3000, 16'hF000, 16'h2000);
		push_layer(0, 0, 20'h30000, 20'h00000, 16'hD000, 16'h3000, 16'hF000, 16'h2000);
		push_layer(0, 1, 20'h30000, 20'h10000, 16'hD000, 16'h8000, 16'h8000, 16'h2000);
		push_layer(1, 1, LEN_MAX, LEN_MAX, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		push_layer(1, 1, 20'h00001, 20'h00001, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF);
		push_layer(1, 1, 20'h00001, 20'h00010, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		for (int i = 0; i < 5; i++)
			push_layer(i == 0, i == 4, LEN_MAX, 20'h10001, 16'hFFFF, 16'h0000, 16'hFFFF,
				16'hFFFF);
		push_layer(0, 1, LEN_MAX, 20'h00100, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);

		for (int ph = 0; ph < 6; ph++) begin
			finish_phase();
			case (ph / 2)
				0: begin
					in_idle_pct = 15;
					out_stall_pct = 64;
				end
				1: begin
					in_idle_pct = 64;
					out_stall_pct = 15;
				end
				default: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
			endcase
			case (ph)
				0: thr = '0;
				1: thr = LEN_MAX;
				2: thr = 20'h20000;
				3: thr = len_t'($urandom_range(0, LEN_MAX));
				4: thr = 20'h00001;
				default: thr = 20'h08000;
			endcase
			cfg_we <= 1'b1;
			cfg_wdata <= thr;
			@(negedge clk);
			cfg_we <= 1'b0;
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					push_noise();
					count++;
				end else begin
					push_cell(count);
				end
			end
		end
		finish_phase();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
